FILE: sv/ssr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sparse set block.
// No dependencies; imported by the output register, the top level and the testbench.
package ssr_pkg;

   // Fixed field widths of the request and response words.
   localparam int FuncW   = 2;
   localparam int IdFldW  = 10;
   localparam int StatW   = 2;
   localparam int CountFW = 11;

   // Operation codes.
   localparam logic [FuncW-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FuncW-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_POP    = 2'd2;

   // Status codes.
   localparam logic [StatW-1:0] ST_DONE    = 2'd0;
   localparam logic [StatW-1:0] ST_PRESENT = 2'd1;
   localparam logic [StatW-1:0] ST_ABSENT  = 2'd2;
   localparam logic [StatW-1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic [FuncW-1:0]  func;
      logic [IdFldW-1:0] item_id;
   } req_type;

   typedef struct packed {
      logic [StatW-1:0]   status;
      logic [IdFldW-1:0]  popped_id;
      logic [CountFW-1:0] member_count;
   } rsp_type;

endpackage

FILE: sv/sparse_set_swap_remove_top.sv
`timescale 1ns / 1ps
// Sparse set of ids with swap-remove: sequencer, two table RAMs, output register.
// Depends on ssr_pkg, ssr_ram and ssr_out_reg.
//
//   Channel   Ports                          Word
//   -------   ----------------------------   -----------------------------------
//   request   req_valid, req_ready, req_data   func, item_id
//   response  rsp_valid, rsp_ready, rsp_data   status, popped_id, member_count
//
// Each word goes through a table read, then an update; an erase that moves
// the last member also needs a move step, since the id table has a single
// write port. After reset a clearing pass over all ID_RANGE id table entries
// zeroes the presence marks; no request word is taken until it ends.
// A full output register holds the sequencer in its update or move state.
module sparse_set_swap_remove_top
   import ssr_pkg::*;
#(
   parameter int ID_RANGE = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IdW  = $clog2(ID_RANGE);
   localparam int CntW = $clog2(ID_RANGE + 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_MOVE  = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdW-1:0]  clr_ff,   clr_in;
   req_type         cur_ff,   cur_in;

   // Id table entry: present mark on top, dense slot below.
   logic            idt_we, idt_re;
   logic [IdW-1:0]  idt_waddr, idt_raddr;
   logic [IdW:0]    idt_wdata, idt_rd;
   logic            dns_we, dns_re;
   logic [IdW-1:0]  dns_waddr, dns_raddr;
   logic [IdW-1:0]  dns_wdata, dns_rd;

   logic            res_load, out_free;
   rsp_type         res_data;

   logic            oor, full, present;
   logic [IdW-1:0]  cur_id, slot;
   logic [CntW-1:0] last;

   ssr_ram #(.WIDTH(IdW + 1), .DEPTH(ID_RANGE)) u_id_table (
      .clock   (clock),
      .wr_en   (idt_we),
      .wr_addr (idt_waddr),
      .wr_data (idt_wdata),
      .rd_en   (idt_re),
      .rd_addr (idt_raddr),
      .rd_data (idt_rd)
   );

   ssr_ram #(.WIDTH(IdW), .DEPTH(ID_RANGE)) u_dense (
      .clock   (clock),
      .wr_en   (dns_we),
      .wr_addr (dns_waddr),
      .wr_data (dns_wdata),
      .rd_en   (dns_re),
      .rd_addr (dns_raddr),
      .rd_data (dns_rd)
   );

   ssr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .load_data (res_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Decode of the held request and the table read data.
   assign cur_id  = IdW'(cur_ff.item_id);
   assign oor     = 32'(cur_ff.item_id) >= 32'(ID_RANGE);
   assign full    = 32'(count_ff) >= 32'(ID_RANGE);
   assign present = idt_rd[IdW];
   assign slot    = idt_rd[IdW-1:0];
   assign last    = count_ff - CntW'(1);

   // Sequencer: clear pass, accept and read, update, optional move fix-up.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      req_ready = 1'b0;
      idt_we    = 1'b0;
      idt_waddr = cur_id;
      idt_wdata = '0;
      idt_re    = 1'b0;
      idt_raddr = IdW'(req_data.item_id);
      dns_we    = 1'b0;
      dns_waddr = slot;
      dns_wdata = dns_rd;
      dns_re    = 1'b0;
      dns_raddr = IdW'(count_ff - CntW'(1));
      res_load  = 1'b0;
      res_data.status    = ST_DONE;
      res_data.popped_id = '0;

      case (state_ff)
         S_CLEAR: begin
            idt_we    = 1'b1;
            idt_waddr = clr_ff;
            clr_in    = clr_ff + IdW'(1);
            if (clr_ff == IdW'(ID_RANGE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in   = req_data;
               idt_re   = 1'b1;
               dns_re   = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cur_ff.func)
               FUNC_INSERT: begin
                  if (oor) begin
                     res_data.status = ST_ABSENT;
                  end else if (present || full) begin
                     res_data.status = ST_PRESENT;
                  end else if (out_free) begin
                     idt_we    = 1'b1;
                     idt_wdata = {1'b1, IdW'(count_ff)};
                     dns_we    = 1'b1;
                     dns_waddr = IdW'(count_ff);
                     dns_wdata = cur_id;
                     count_in  = count_ff + CntW'(1);
                  end
                  res_load = out_free;
               end
               FUNC_ERASE: begin
                  if (oor || count_ff == '0 || !present) begin
                     res_data.status = ST_ABSENT;
                     res_load        = out_free;
                  end else if (CntW'(slot) != last) begin
                     // Clear the id and move the last member into its slot.
                     idt_we   = 1'b1;
                     dns_we   = 1'b1;
                     state_in = S_MOVE;
                  end else if (out_free) begin
                     idt_we   = 1'b1;
                     count_in = last;
                     res_load = 1'b1;
                  end
               end
               FUNC_POP: begin
                  if (count_ff == '0) begin
                     res_data.status = ST_EMPTY;
                  end else if (out_free) begin
                     idt_we             = 1'b1;
                     idt_waddr          = dns_rd;
                     count_in           = last;
                     res_data.popped_id = IdFldW'(dns_rd);
                  end
                  res_load = out_free;
               end
               default: begin
                  res_load = out_free;
               end
            endcase
            if (res_load) begin
               state_in = S_IDLE;
            end
         end
         S_MOVE: begin
            // Point the moved member at its new slot.
            if (out_free) begin
               idt_we    = 1'b1;
               idt_waddr = dns_rd;
               idt_wdata = {1'b1, slot};
               count_in  = last;
               res_load  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res_data.member_count = CountFW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
      cur_ff <= cur_in;
   end

   // An accepted word always moves the sequencer into its update cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted word did not enter the update cycle");

   // The member count only changes when a response is loaded.
   assert property (@(posedge clock) disable iff (reset)
      !res_load |=> $stable(count_ff))
      else $error("member count changed without a response");

   // A response is only loaded into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("response loaded into a full output register");

   // The count never exceeds the id range.
   assert property (@(posedge clock) disable iff (reset)
      res_load |=> 32'(count_ff) <= 32'(ID_RANGE))
      else $error("member count beyond id range");

endmodule

FILE: sv/ssr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ssr_out_reg.sv
`timescale 1ns / 1ps
// Response output register: holds one finished word until it is taken.
// Depends on ssr_pkg for the response word type.
module ssr_out_reg
   import ssr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   // A new word may enter when the register is empty or is being drained.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load && free) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: test/tb_sparse_set_swap_remove_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sparse set block with swap-remove.
// Depends on ssr_pkg and sparse_set_swap_remove_top; keeps its own shadow of the set.
module tb_sparse_set_swap_remove_top
   import ssr_pkg::*;
();

   localparam int IdRange = 1024;
   localparam logic [FuncW-1:0]  FUNC_UNUSED = 2'd3;
   localparam logic [IdFldW-1:0] ID_LAST     = 10'd1023;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the set: dense member array, position table and presence marks.
   bit                  shadow_present [IdRange];
   logic [IdFldW-1:0]   shadow_slot    [IdRange];
   logic [IdFldW-1:0]   shadow_dense   [IdRange];
   logic [CountFW-1:0]  shadow_count = '0;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   bit      idle_on = 1'b1;

   sparse_set_swap_remove_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Applies one request word to the shadow set and returns the response it must give.
   function automatic rsp_type apply_set_op(req_type w);
      rsp_type           r;
      logic [IdFldW-1:0] pos;
      logic [IdFldW-1:0] last;
      logic [IdFldW-1:0] moved;
      r = '0;
      r.status = ST_DONE;
      case (w.func)
         FUNC_INSERT: begin
            if (shadow_present[w.item_id]) begin
               r.status = ST_PRESENT;
            end else if (shadow_count >= CountFW'(IdRange)) begin
               // A full set turns away new ids as if they were present.
               r.status = ST_PRESENT;
            end else begin
               shadow_slot[w.item_id]              = shadow_count[IdFldW-1:0];
               shadow_present[w.item_id]           = 1'b1;
               shadow_dense[shadow_count[IdFldW-1:0]] = w.item_id;
               shadow_count                        = shadow_count + 1'b1;
            end
         end
         FUNC_ERASE: begin
            if (shadow_count == 0 || !shadow_present[w.item_id]) begin
               r.status = ST_ABSENT;
            end else begin
               pos  = shadow_slot[w.item_id];
               last = IdFldW'(shadow_count - 1'b1);
               shadow_present[w.item_id] = 1'b0;
               // The last member fills the freed slot unless it is the one erased.
               if (pos != last) begin
                  moved              = shadow_dense[last];
                  shadow_dense[pos]  = moved;
                  shadow_slot[moved] = pos;
               end
               shadow_count = shadow_count - 1'b1;
            end
         end
         FUNC_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count = shadow_count - 1'b1;
               r.popped_id  = shadow_dense[shadow_count[IdFldW-1:0]];
               shadow_present[r.popped_id] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      r.member_count = shadow_count;
      return r;
   endfunction

   // A random current member, or any id when the set is empty.
   function automatic logic [IdFldW-1:0] some_member();
      if (shadow_count == 0) return IdFldW'($urandom_range(IdRange - 1));
      return shadow_dense[$urandom_range(shadow_count - 1)];
   endfunction

   // Sends one request word and records its expected response once it is taken.
   task automatic send_word(logic [FuncW-1:0] f, logic [IdFldW-1:0] id);
      req_type w;
      w.func    = f;
      w.item_id = id;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp = {pending_rsp, apply_set_op(w)};
   endtask

   // Holds the request side off until every expected response is back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Response side stalls at random while idling is on.
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
   end

   // Each response word is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.popped_id !== exp_rsp.popped_id) begin
               $display("%0t: popped_id expected %0d actual %0d",
                        $time, exp_rsp.popped_id, rsp_data.popped_id);
               error_count++;
            end
            if (rsp_data.member_count !== exp_rsp.member_count) begin
               $display("%0t: member_count expected %0d actual %0d",
                        $time, exp_rsp.member_count, rsp_data.member_count);
               error_count++;
            end
         end
      end
   end

   // Empty set, extreme ids, duplicates, swap moves, pop order and the unused code.
   task automatic test_directed();
      send_word(FUNC_POP, 10'd0);
      send_word(FUNC_ERASE, 10'd0);
      send_word(FUNC_ERASE, ID_LAST);
      send_word(FUNC_INSERT, 10'd0);
      send_word(FUNC_INSERT, ID_LAST);
      send_word(FUNC_INSERT, 10'd512);
      send_word(FUNC_INSERT, 10'd0);
      send_word(FUNC_UNUSED, ID_LAST);
      send_word(FUNC_UNUSED, 10'd0);
      send_word(FUNC_ERASE, 10'd0);
      send_word(FUNC_ERASE, 10'd512);
      send_word(FUNC_ERASE, ID_LAST);
      send_word(FUNC_ERASE, ID_LAST);
      send_word(FUNC_POP, ID_LAST);
      send_word(FUNC_INSERT, 10'd5);
      send_word(FUNC_INSERT, 10'h2aa);
      send_word(FUNC_INSERT, 10'h155);
      send_word(FUNC_POP, 10'd0);
      send_word(FUNC_ERASE, 10'd5);
      send_word(FUNC_POP, ID_LAST);
      send_word(FUNC_POP, 10'd0);
      send_word(FUNC_INSERT, 10'h155);
      send_word(FUNC_ERASE, 10'h155);
   endtask

   // Many hits and misses on a narrow window of ids.
   task automatic test_id_pool(int n);
      int                unsigned pick;
      logic [IdFldW-1:0] base;
      base = IdFldW'($urandom_range(IdRange - 16));
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 45)      send_word(FUNC_INSERT, base + IdFldW'($urandom_range(15)));
         else if (pick < 80) send_word(FUNC_ERASE, base + IdFldW'($urandom_range(15)));
         else if (pick < 95) send_word(FUNC_POP, IdFldW'($urandom_range(IdRange - 1)));
         else                send_word(FUNC_UNUSED, IdFldW'($urandom_range(IdRange - 1)));
      end
   endtask

   // Mixed traffic over the full id range; grow selects insert-heavy or erase-heavy.
   task automatic test_full_range(int n, bit grow);
      int unsigned pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (grow) begin
            if (pick < 75)      send_word(FUNC_INSERT, IdFldW'($urandom_range(IdRange - 1)));
            else if (pick < 85) send_word(FUNC_ERASE, some_member());
            else if (pick < 90) send_word(FUNC_ERASE, IdFldW'($urandom_range(IdRange - 1)));
            else if (pick < 95) send_word(FUNC_POP, IdFldW'($urandom_range(IdRange - 1)));
            else                send_word(FUNC_UNUSED, IdFldW'($urandom_range(IdRange - 1)));
         end else begin
            if (pick < 50)      send_word(FUNC_ERASE, some_member());
            else if (pick < 75) send_word(FUNC_POP, IdFldW'($urandom_range(IdRange - 1)));
            else if (pick < 85) send_word(FUNC_INSERT, IdFldW'($urandom_range(IdRange - 1)));
            else if (pick < 95) send_word(FUNC_ERASE, IdFldW'($urandom_range(IdRange - 1)));
            else                send_word(FUNC_UNUSED, IdFldW'($urandom_range(IdRange - 1)));
         end
      end
   endtask

   // Back-to-back words with both sides always willing.
   task automatic test_no_idle(int n);
      idle_on = 1'b0;
      test_full_range(n / 2, 1'b1);
      test_full_range(n - n / 2, 1'b0);
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_id_pool(200);
      wait_drained();
      test_full_range(150, 1'b1);
      test_no_idle(100);
      test_full_range(150, 1'b0);

      // Let the last responses come back, then idle quietly before finishing.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Run limit well beyond the slowest correct run, clearing pass included.
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/ssr_pkg.sv
sv/ssr_ram.sv
sv/ssr_out_reg.sv
sv/sparse_set_swap_remove_top.sv
test/tb_sparse_set_swap_remove_top.sv
